/* src/sfr_pkg.sv */
// Shared types and constants for the soft frequency reuse block group policy.
// Used by the controller, the datapath, the top level and the testbench.
`default_nettype none

package sfr_pkg;

  // table geometry
  localparam int UE_SLOTS   = 64;
  localparam int MAX_BLOCKS = 128;
  localparam int SLOT_W     = $clog2(UE_SLOTS);
  localparam int CNT_W      = $clog2(UE_SLOTS + 1);

  // input item kinds
  localparam logic [1:0] KIND_DL     = 2'd0;
  localparam logic [1:0] KIND_UL     = 2'd1;
  localparam logic [1:0] KIND_TPC    = 2'd2;
  localparam logic [1:0] KIND_REPORT = 2'd3;

  // terminal area codes
  localparam logic [1:0] AREA_UNSET  = 2'd0;
  localparam logic [1:0] AREA_CENTRE = 2'd1;
  localparam logic [1:0] AREA_EDGE   = 2'd2;

  // tpc code for an unknown or unset terminal
  localparam logic [1:0] TPC_DEFAULT = 2'd1;

  // configuration register indexes
  localparam logic [2:0] CFG_DL_EDGE_OFFSET = 3'd0;
  localparam logic [2:0] CFG_DL_EDGE_WIDTH  = 3'd1;
  localparam logic [2:0] CFG_DL_GROUP_SIZE  = 3'd2;
  localparam logic [2:0] CFG_UL_EDGE_OFFSET = 3'd3;
  localparam logic [2:0] CFG_UL_EDGE_WIDTH  = 3'd4;
  localparam logic [2:0] CFG_QUALITY_THR    = 3'd5;
  localparam logic [2:0] CFG_MODE_FLAGS     = 3'd6;
  localparam logic [2:0] CFG_AREA_SETTINGS  = 3'd7;

  // commands from the controller to the datapath
  typedef struct packed {
    logic start;   // load request, clear scan state
    logic step;    // advance the table scan by one entry
    logic commit;  // update table and load the result register
  } sfr_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic scan_done;    // every slot compared
    logic out_blocked;  // result register full and not taken this cycle
  } sfr_status_t;

endpackage

`default_nettype wire

/* src/sfr_ctrl.sv */
// Controller state machine for the soft frequency reuse block group policy.
// Depends on sfr_pkg for the command and status structs.
`default_nettype none

module sfr_ctrl import sfr_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  sfr_status_t      status,
  output sfr_cmd_t         cmd
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_COMMIT = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.start  = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (status.scan_done) begin
          state_next = ST_COMMIT;
        end else begin
          cmd.step = 1'b1;
        end
      end
      ST_COMMIT: begin
        if (!status.out_blocked) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // one item in flight at a time
  assign in_stall = (state != ST_IDLE);

endmodule

`default_nettype wire

/* src/sfr_datapath.sv */
// Datapath: configuration registers, terminal table, scan logic and result register.
// Depends on sfr_pkg; driven by sfr_ctrl through sfr_cmd_t.
`default_nettype none

module sfr_datapath import sfr_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  sfr_cmd_t         cmd,
  output sfr_status_t      status,
  input  wire logic        cfg_valid,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [9:0]  cfg_data,
  input  wire logic [1:0]  kind,
  input  wire logic [15:0] rnti,
  input  wire logic [6:0]  group_index,
  input  wire logic [5:0]  report_id,
  input  wire logic [7:0]  rsrq,
  input  wire logic        out_stall,
  output logic             out_valid,
  output logic             available,
  output logic [1:0]       tpc_code,
  output logic             pa_changed,
  output logic [2:0]       pa_value,
  output logic             report_ignored,
  output logic             table_full
);

  localparam int ENTRY_W = 18;

  // floor(x / s) for group sizes 1..7 by shift or reciprocal (exact below 256)
  function automatic logic [7:0] div_size(input logic [7:0] x, input logic [2:0] s);
    logic [16:0] prod3;
    logic [16:0] prod5;
    logic [16:0] prod7;
    begin
      prod3 = {9'd0, x} * 17'd171;
      prod5 = {9'd0, x} * 17'd205;
      prod7 = {9'd0, x} * 17'd293;
      case (s)
        3'd2:    div_size = {1'b0, x[7:1]};
        3'd3:    div_size = prod3[16:9];
        3'd4:    div_size = {2'b00, x[7:2]};
        3'd5:    div_size = {1'b0, prod5[16:10]};
        3'd6:    div_size = {1'b0, prod3[16:10]};
        3'd7:    div_size = {2'b00, prod7[16:11]};
        default: div_size = x;
      endcase
    end
  endfunction

  // configuration registers
  logic [6:0] dl_edge_offset;
  logic [6:0] dl_edge_width;
  logic [2:0] dl_group_size;
  logic [6:0] ul_edge_offset;
  logic [6:0] ul_edge_width;
  logic [7:0] quality_threshold;
  logic [7:0] mode_flags;
  logic [9:0] area_settings;

  always_ff @(posedge clk) begin
    if (rst) begin
      dl_edge_offset    <= 7'd0;
      dl_edge_width     <= 7'd0;
      dl_group_size     <= 3'd1;
      ul_edge_offset    <= 7'd0;
      ul_edge_width     <= 7'd0;
      quality_threshold <= 8'd20;
      mode_flags        <= 8'd3;
      area_settings     <= 10'd365;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_DL_EDGE_OFFSET: dl_edge_offset    <= cfg_data[6:0];
        CFG_DL_EDGE_WIDTH:  dl_edge_width     <= cfg_data[6:0];
        CFG_DL_GROUP_SIZE:  dl_group_size     <= cfg_data[2:0];
        CFG_UL_EDGE_OFFSET: ul_edge_offset    <= cfg_data[6:0];
        CFG_UL_EDGE_WIDTH:  ul_edge_width     <= cfg_data[6:0];
        CFG_QUALITY_THR:    quality_threshold <= cfg_data[7:0];
        CFG_MODE_FLAGS:     mode_flags        <= cfg_data[7:0];
        CFG_AREA_SETTINGS:  area_settings     <= cfg_data;
        default: ;
      endcase
    end
  end

  // request registers
  logic [1:0]  req_kind;
  logic [15:0] req_rnti;
  logic [6:0]  req_group;
  logic [5:0]  req_report_id;
  logic [7:0]  req_rsrq;

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      req_kind      <= kind;
      req_rnti      <= rnti;
      req_group     <= group_index;
      req_report_id <= report_id;
      req_rsrq      <= rsrq;
    end
  end

  // terminal table: key and area per slot, valid bits in flops
  logic [ENTRY_W-1:0]  slot_mem [UE_SLOTS];
  logic [ENTRY_W-1:0]  rd_data;
  logic [UE_SLOTS-1:0] slot_valid;
  logic [CNT_W-1:0]    cnt;
  logic                mem_we;
  logic [SLOT_W-1:0]   mem_wa;
  logic [ENTRY_W-1:0]  mem_wd;
  logic                set_valid;

  always_ff @(posedge clk) begin
    if (cmd.commit && mem_we) begin
      slot_mem[mem_wa] <= mem_wd;
    end
    rd_data <= slot_mem[cnt[SLOT_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
    end else if (cmd.commit && set_valid) begin
      slot_valid[mem_wa] <= 1'b1;
    end
  end

  // scan: read one slot per cycle, compare it the cycle after
  logic              rd_pend;
  logic [SLOT_W-1:0] rd_idx;
  logic              hit;
  logic [SLOT_W-1:0] hit_idx;
  logic [1:0]        hit_area;
  logic              free_found;
  logic [SLOT_W-1:0] free_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt        <= '0;
      rd_pend    <= 1'b0;
      hit        <= 1'b0;
      free_found <= 1'b0;
    end else if (cmd.start) begin
      cnt        <= '0;
      rd_pend    <= 1'b0;
      hit        <= 1'b0;
      free_found <= 1'b0;
    end else begin
      if (rd_pend) begin
        if (slot_valid[rd_idx] && rd_data[ENTRY_W-1:2] == req_rnti) begin
          hit      <= 1'b1;
          hit_idx  <= rd_idx;
          hit_area <= rd_data[1:0];
        end
        if (!slot_valid[rd_idx] && !free_found) begin
          free_found <= 1'b1;
          free_idx   <= rd_idx;
        end
      end
      if (cmd.step) begin
        rd_pend <= (cnt != CNT_W'(UE_SLOTS));
        rd_idx  <= cnt[SLOT_W-1:0];
        if (cnt != CNT_W'(UE_SLOTS)) begin
          cnt <= cnt + CNT_W'(1);
        end
      end
    end
  end

  assign status.scan_done   = (cnt == CNT_W'(UE_SLOTS)) && !rd_pend;
  assign status.out_blocked = out_valid && out_stall;

  // edge sub-band tests
  logic [2:0] dl_size;
  logic [7:0] dl_lo;
  logic [7:0] dl_hi;
  logic [7:0] ul_hi;
  logic [7:0] grp8;
  logic       dl_edge_g;
  logic       ul_edge_g;

  assign dl_size   = (dl_group_size == 3'd0) ? 3'd1 : dl_group_size;
  assign dl_lo     = div_size({1'b0, dl_edge_offset}, dl_size);
  assign dl_hi     = div_size({1'b0, dl_edge_offset} + {1'b0, dl_edge_width}, dl_size);
  assign ul_hi     = {1'b0, ul_edge_offset} + {1'b0, ul_edge_width};
  assign grp8      = {1'b0, req_group};
  assign dl_edge_g = (grp8 < 8'(MAX_BLOCKS)) && (grp8 >= dl_lo) && (grp8 < dl_hi);
  assign ul_edge_g = (grp8 < 8'(MAX_BLOCKS)) && (grp8 >= {1'b0, ul_edge_offset})
                     && (grp8 < ul_hi);

  // result and table update decision
  logic       ul_on;
  logic       edge_g;
  logic       edge_ue;
  logic [1:0] want;
  logic [1:0] cur_area;
  logic       c_avail;
  logic [1:0] c_tpc;
  logic       c_changed;
  logic [2:0] c_pa;
  logic       c_ignored;
  logic       c_full;

  assign ul_on    = mode_flags[1];
  assign edge_g   = (req_kind == KIND_DL) ? dl_edge_g : ul_edge_g;
  assign edge_ue  = (hit_area == AREA_EDGE);
  assign want     = (req_rsrq < quality_threshold) ? AREA_EDGE : AREA_CENTRE;
  assign cur_area = hit ? hit_area : AREA_UNSET;

  always_comb begin
    c_avail   = 1'b0;
    c_tpc     = 2'd0;
    c_changed = 1'b0;
    c_pa      = 3'd0;
    c_ignored = 1'b0;
    c_full    = 1'b0;
    mem_we    = 1'b0;
    set_valid = 1'b0;
    mem_wa    = free_idx;
    mem_wd    = {req_rnti, AREA_UNSET};
    case (req_kind)
      KIND_DL, KIND_UL: begin
        if (req_kind == KIND_UL && !ul_on) begin
          c_avail = 1'b1;
        end else if (!hit) begin
          // unknown terminal: insert as unset when a slot is free
          c_avail = !edge_g;
          if (free_found) begin
            mem_we    = 1'b1;
            set_valid = 1'b1;
          end else begin
            c_full = 1'b1;
          end
        end else if (!edge_ue && mode_flags[0]) begin
          c_avail = 1'b1;
        end else begin
          c_avail = (edge_g == edge_ue);
        end
      end
      KIND_TPC: begin
        c_tpc = TPC_DEFAULT;
        if (ul_on && hit) begin
          if (hit_area == AREA_EDGE) begin
            c_tpc = area_settings[9:8];
          end else if (hit_area == AREA_CENTRE) begin
            c_tpc = area_settings[7:6];
          end
        end
      end
      KIND_REPORT: begin
        if (req_report_id != mode_flags[7:2]) begin
          c_ignored = 1'b1;
        end else if (!hit && !free_found) begin
          c_full = 1'b1;
        end else if (cur_area != want) begin
          // new terminal always lands here since want is never unset
          c_changed = 1'b1;
          c_pa      = (want == AREA_EDGE) ? area_settings[5:3] : area_settings[2:0];
          mem_we    = 1'b1;
          set_valid = !hit;
          mem_wa    = hit ? hit_idx : free_idx;
          mem_wd    = {req_rnti, want};
        end
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      available      <= c_avail;
      tpc_code       <= c_tpc;
      pa_changed     <= c_changed;
      pa_value       <= c_pa;
      report_ignored <= c_ignored;
      table_full     <= c_full;
    end
  end

endmodule

`default_nettype wire

/* src/soft_frequency_reuse_rbg_policy.sv */
// Soft frequency reuse block group policy: terminal area table and edge sub-band check.
// Top level joining sfr_ctrl and sfr_datapath; depends on sfr_pkg.
//
// Usage:
//  - Input channel (in_valid / in_stall): one query or measurement report per transfer
//    (kind, rnti, group_index, report_id, rsrq). in_stall is high while an item is in work.
//  - Output channel (out_valid / out_stall): exactly one result per input item.
//  - Config channel (cfg_valid / cfg_ready, cfg_index, cfg_data): cfg_ready is always high;
//    write registers only while no item is in work.
//  - Every item scans the whole terminal table, one slot per cycle through the slot memory
//    read port, and the next item is taken the cycle after its result is loaded.
//  - The result sits in an output register; the next item is taken and scanned while it
//    waits. If the receiver stalls, the finished item waits for the register to empty.
//  - Reset clears the slot valid bits at once (no clearing pass) and restores register
//    defaults; no result is pending after reset.
`default_nettype none

module soft_frequency_reuse_rbg_policy import sfr_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  kind,
  input  wire logic [15:0] rnti,
  input  wire logic [6:0]  group_index,
  input  wire logic [5:0]  report_id,
  input  wire logic [7:0]  rsrq,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             available,
  output logic [1:0]       tpc_code,
  output logic             pa_changed,
  output logic [2:0]       pa_value,
  output logic             report_ignored,
  output logic             table_full,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [9:0]  cfg_data
);

  sfr_cmd_t    cmd;
  sfr_status_t status;

  // registers accept writes at any time
  assign cfg_ready = 1'b1;

  // controller
  sfr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // datapath
  sfr_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .cfg_valid      (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .kind           (kind),
    .rnti           (rnti),
    .group_index    (group_index),
    .report_id      (report_id),
    .rsrq           (rsrq),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .available      (available),
    .tpc_code       (tpc_code),
    .pa_changed     (pa_changed),
    .pa_value       (pa_value),
    .report_ignored (report_ignored),
    .table_full     (table_full)
  );

endmodule

`default_nettype wire

/* src/sfr_checker.sv */
// Port-level checker for soft_frequency_reuse_rbg_policy, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none

module sfr_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic       available,
  input wire logic       pa_changed,
  input wire logic       report_ignored,
  input wire logic       table_full
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // an accepted item blocks the input until its result is loaded
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while an item is in work");

  // a new result appears only as the block returns to idle
  a_result_frees_input: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !in_stall)
    else $error("result loaded while still busy");

  // an ignored report leaves every other flag clear
  a_ignored_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && report_ignored |-> !pa_changed && !table_full && !available)
    else $error("ignored report carries other flags");

  // an area change needs a table slot
  a_change_not_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && pa_changed |-> !table_full)
    else $error("area change reported with full table");

endmodule

bind soft_frequency_reuse_rbg_policy sfr_checker u_sfr_checker (.*);

`default_nettype wire

/* verif/tb_soft_frequency_reuse_rbg_policy.sv */
`timescale 1ns / 100ps
// Testbench for soft_frequency_reuse_rbg_policy: a directed table, then random traffic,
// each result checked against the row's fixed expectation or an in-bench copy of the
// terminal table and sub-band rules. Depends on sfr_pkg and the RTL of the block.

module tb_soft_frequency_reuse_rbg_policy;
  import sfr_pkg::*;

  localparam int PHASE_ITEMS = 445;
  localparam int POOL_SIZE   = 96;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] rnti;
    logic [6:0]  group_index;
    logic [5:0]  report_id;
    logic [7:0]  rsrq;
  } policy_item_t;

  typedef struct packed {
    logic       available;
    logic [1:0] tpc_code;
    logic       pa_changed;
    logic [2:0] pa_value;
    logic       report_ignored;
    logic       table_full;
  } policy_result_t;

  typedef struct packed {
    policy_item_t   item;
    logic           typed;
    policy_result_t want;
  } stim_row_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  kind;
  logic [15:0] rnti;
  logic [6:0]  group_index;
  logic [5:0]  report_id;
  logic [7:0]  rsrq;
  logic        out_valid;
  logic        out_stall;
  logic        available;
  logic [1:0]  tpc_code;
  logic        pa_changed;
  logic [2:0]  pa_value;
  logic        report_ignored;
  logic        table_full;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [9:0]  cfg_data;

  // register copies held by the bench
  logic [6:0] dl_off_q;
  logic [6:0] dl_wid_q;
  logic [2:0] dl_size_q;
  logic [6:0] ul_off_q;
  logic [6:0] ul_wid_q;
  logic [7:0] thr_q;
  logic [7:0] mode_q;
  logic [9:0] area_q;

  // terminal table copy
  logic        tbl_used [UE_SLOTS];
  logic [15:0] tbl_rnti [UE_SLOTS];
  logic [1:0]  tbl_area [UE_SLOTS];

  policy_result_t pending_results [$];
  stim_row_t      directed_rows [$];
  logic [9:0]     reg_plan [8];
  logic [15:0]    rnti_pool [POOL_SIZE];
  int             send_idle_pct;
  int             recv_idle_pct;
  int             mismatch_count;

  soft_frequency_reuse_rbg_policy u_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .kind           (kind),
    .rnti           (rnti),
    .group_index    (group_index),
    .report_id      (report_id),
    .rsrq           (rsrq),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .available      (available),
    .tpc_code       (tpc_code),
    .pa_changed     (pa_changed),
    .pa_value       (pa_value),
    .report_ignored (report_ignored),
    .table_full     (table_full),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // table lookup and insertion
  function automatic int find_terminal(logic [15:0] id);
    for (int i = 0; i < UE_SLOTS; i++) begin
      if (tbl_used[i] && tbl_rnti[i] == id) return i;
    end
    return -1;
  endfunction

  function automatic int add_terminal(logic [15:0] id);
    for (int i = 0; i < UE_SLOTS; i++) begin
      if (!tbl_used[i]) begin
        tbl_used[i] = 1'b1;
        tbl_rnti[i] = id;
        tbl_area[i] = AREA_UNSET;
        return i;
      end
    end
    return -1;
  endfunction

  // sub-band membership, group size zero behaves as one
  function automatic logic dl_group_is_edge(logic [6:0] g);
    int sz, lo, hi;
    sz = (dl_size_q == 3'd0) ? 1 : int'(dl_size_q);
    lo = int'(dl_off_q) / sz;
    hi = (int'(dl_off_q) + int'(dl_wid_q)) / sz;
    return int'(g) < MAX_BLOCKS && int'(g) >= lo && int'(g) < hi;
  endfunction

  function automatic logic ul_block_is_edge(logic [6:0] b);
    return int'(b) < MAX_BLOCKS && int'(b) >= int'(ul_off_q) &&
           int'(b) < int'(ul_off_q) + int'(ul_wid_q);
  endfunction

  // expected result of one item, updating the table copy
  function automatic policy_result_t predict_policy(policy_item_t it);
    policy_result_t r;
    int             s;
    logic           grp_edge;
    logic [1:0]     want_area;
    r = '0;
    case (it.kind)
      KIND_DL, KIND_UL: begin
        if (it.kind == KIND_UL && !mode_q[1]) begin
          r.available = 1'b1;
        end else begin
          grp_edge = (it.kind == KIND_DL) ? dl_group_is_edge(it.group_index)
                                          : ul_block_is_edge(it.group_index);
          s = find_terminal(it.rnti);
          if (s < 0) begin
            if (add_terminal(it.rnti) < 0) r.table_full = 1'b1;
            r.available = !grp_edge;
          end else if (tbl_area[s] != AREA_EDGE && mode_q[0]) begin
            r.available = 1'b1;
          end else begin
            r.available = (grp_edge == (tbl_area[s] == AREA_EDGE));
          end
        end
      end
      KIND_TPC: begin
        r.tpc_code = TPC_DEFAULT;
        s = mode_q[1] ? find_terminal(it.rnti) : -1;
        if (s >= 0) begin
          if (tbl_area[s] == AREA_EDGE) r.tpc_code = area_q[9:8];
          else if (tbl_area[s] == AREA_CENTRE) r.tpc_code = area_q[7:6];
        end
      end
      KIND_REPORT: begin
        if (it.report_id != mode_q[7:2]) begin
          r.report_ignored = 1'b1;
        end else begin
          s = find_terminal(it.rnti);
          if (s < 0) s = add_terminal(it.rnti);
          if (s < 0) begin
            r.table_full = 1'b1;
          end else begin
            want_area = (it.rsrq < thr_q) ? AREA_EDGE : AREA_CENTRE;
            if (tbl_area[s] != want_area) begin
              tbl_area[s]  = want_area;
              r.pa_changed = 1'b1;
              r.pa_value   = (want_area == AREA_EDGE) ? area_q[5:3] : area_q[2:0];
            end
          end
        end
      end
    endcase
    return r;
  endfunction

  function automatic policy_result_t outcome(logic avail, logic [1:0] tpc, logic chg,
                                             logic [2:0] pa, logic ign, logic full);
    policy_result_t r;
    r.available      = avail;
    r.tpc_code       = tpc;
    r.pa_changed     = chg;
    r.pa_value       = pa;
    r.report_ignored = ign;
    r.table_full     = full;
    return r;
  endfunction

  task automatic add_row(logic [1:0] k, logic [15:0] id, logic [6:0] grp, logic [5:0] rid,
                         logic [7:0] q, logic typed, policy_result_t want);
    stim_row_t row;
    row.item.kind        = k;
    row.item.rnti        = id;
    row.item.group_index = grp;
    row.item.report_id   = rid;
    row.item.rsrq        = q;
    row.typed            = typed;
    row.want             = want;
    directed_rows.push_back(row);
  endtask

  // register write in the bench copy
  function automatic void apply_reg(logic [2:0] idx, logic [9:0] data);
    case (idx)
      CFG_DL_EDGE_OFFSET: dl_off_q  = data[6:0];
      CFG_DL_EDGE_WIDTH:  dl_wid_q  = data[6:0];
      CFG_DL_GROUP_SIZE:  dl_size_q = data[2:0];
      CFG_UL_EDGE_OFFSET: ul_off_q  = data[6:0];
      CFG_UL_EDGE_WIDTH:  ul_wid_q  = data[6:0];
      CFG_QUALITY_THR:    thr_q     = data[7:0];
      CFG_MODE_FLAGS:     mode_q    = data[7:0];
      CFG_AREA_SETTINGS:  area_q    = data;
      default: ;
    endcase
  endfunction

  // write all eight registers back to back, called at a falling edge
  task automatic program_regs();
    for (int i = 0; i < 8; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= 3'(i);
      cfg_data  <= reg_plan[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      apply_reg(3'(i), reg_plan[i]);
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  // register settings and idle rates of each phase
  task automatic plan_phase(int p);
    case (p)
      0: begin
        reg_plan[CFG_DL_EDGE_OFFSET] = 10'd8;
        reg_plan[CFG_DL_EDGE_WIDTH]  = 10'd16;
        reg_plan[CFG_DL_GROUP_SIZE]  = 10'd4;
        reg_plan[CFG_UL_EDGE_OFFSET] = 10'd120;
        reg_plan[CFG_UL_EDGE_WIDTH]  = 10'd7;
        reg_plan[CFG_QUALITY_THR]    = 10'd100;
        reg_plan[CFG_MODE_FLAGS]     = {2'b00, 6'd5, 2'b10};
        reg_plan[CFG_AREA_SETTINGS]  = {2'd3, 2'd2, 3'd6, 3'd3};
      end
      1: begin
        reg_plan[CFG_DL_EDGE_OFFSET] = 10'd0;
        reg_plan[CFG_DL_EDGE_WIDTH]  = 10'd100;
        reg_plan[CFG_DL_GROUP_SIZE]  = 10'd1;
        reg_plan[CFG_UL_EDGE_OFFSET] = 10'd0;
        reg_plan[CFG_UL_EDGE_WIDTH]  = 10'd100;
        reg_plan[CFG_QUALITY_THR]    = 10'd255;
        reg_plan[CFG_MODE_FLAGS]     = {2'b00, 6'($urandom_range(63)), 2'b11};
        reg_plan[CFG_AREA_SETTINGS]  = 10'd1023;
      end
      2: begin
        reg_plan[CFG_DL_EDGE_OFFSET] = 10'd127;
        reg_plan[CFG_DL_EDGE_WIDTH]  = 10'd127;
        reg_plan[CFG_DL_GROUP_SIZE]  = 10'd7;
        reg_plan[CFG_UL_EDGE_OFFSET] = 10'd127;
        reg_plan[CFG_UL_EDGE_WIDTH]  = 10'd127;
        reg_plan[CFG_QUALITY_THR]    = 10'd0;
        reg_plan[CFG_MODE_FLAGS]     = {2'b00, 6'd63, 2'b01};
        reg_plan[CFG_AREA_SETTINGS]  = 10'd0;
      end
      3: begin
        reg_plan[CFG_DL_EDGE_OFFSET] = 10'd50;
        reg_plan[CFG_DL_EDGE_WIDTH]  = 10'd30;
        reg_plan[CFG_DL_GROUP_SIZE]  = 10'd0;
        reg_plan[CFG_UL_EDGE_OFFSET] = 10'd10;
        reg_plan[CFG_UL_EDGE_WIDTH]  = 10'd40;
        reg_plan[CFG_QUALITY_THR]    = 10'd128;
        reg_plan[CFG_MODE_FLAGS]     = {2'b00, 6'($urandom_range(63)), 2'b10};
        reg_plan[CFG_AREA_SETTINGS]  = 10'($urandom_range(1023));
      end
      default: begin
        for (int i = 0; i < 8; i++) reg_plan[i] = 10'($urandom_range(1023));
      end
    endcase
    send_idle_pct = (p <= 1) ? 28 : (p == 2) ? 49 : 0;
    recv_idle_pct = (p <= 1) ? 49 : (p == 2) ? 28 : 0;
  endtask

  // hold the input side until every expected result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // one input transfer, entered and left at a falling edge
  task automatic send_item(policy_item_t it, logic typed, policy_result_t want);
    policy_result_t model;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    kind        <= it.kind;
    rnti        <= it.rnti;
    group_index <= it.group_index;
    report_id   <= it.report_id;
    rsrq        <= it.rsrq;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    model = predict_policy(it);
    pending_results.push_back(typed ? want : model);
    @(negedge clk);
  endtask

  // random stall on the result side
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    policy_result_t got;
    policy_result_t oldest;
    if (!rst && out_valid && !out_stall) begin
      got = outcome(available, tpc_code, pa_changed, pa_value, report_ignored, table_full);
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: result with nothing pending: avail %0d tpc %0d chg %0d pa %0d",
                   $realtime, got.available, got.tpc_code, got.pa_changed, got.pa_value);
      end else begin
        oldest = pending_results.pop_front();
        if (got !== oldest) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("%0t: mismatch exp avail %0d tpc %0d chg %0d pa %0d ign %0d full %0d",
                     $realtime, oldest.available, oldest.tpc_code, oldest.pa_changed,
                     oldest.pa_value, oldest.report_ignored, oldest.table_full);
            $display("           got avail %0d tpc %0d chg %0d pa %0d ign %0d full %0d",
                     got.available, got.tpc_code, got.pa_changed, got.pa_value,
                     got.report_ignored, got.table_full);
          end
        end
      end
    end
  end

  // run limit
  initial begin
    #15_000_000;
    $display("[soft_frequency_reuse_rbg_policy] ERROR");
    $finish;
  end

  initial begin
    policy_item_t it;
    int           pick;
    rst            = 1'b1;
    in_valid       = 1'b0;
    kind           = KIND_DL;
    rnti           = '0;
    group_index    = '0;
    report_id      = '0;
    rsrq           = '0;
    out_stall      = 1'b0;
    cfg_valid      = 1'b0;
    cfg_index      = CFG_DL_EDGE_OFFSET;
    cfg_data       = '0;
    send_idle_pct  = 0;
    recv_idle_pct  = 0;
    mismatch_count = 0;

    // register defaults and empty table after reset
    dl_off_q  = 7'd0;
    dl_wid_q  = 7'd0;
    dl_size_q = 3'd1;
    ul_off_q  = 7'd0;
    ul_wid_q  = 7'd0;
    thr_q     = 8'd20;
    mode_q    = 8'd3;
    area_q    = 10'd365;
    for (int i = 0; i < UE_SLOTS; i++) tbl_used[i] = 1'b0;

    rnti_pool[0] = 16'h0000;
    rnti_pool[1] = 16'hFFFF;
    for (int i = 2; i < POOL_SIZE; i++) rnti_pool[i] = 16'($urandom);

    // directed rows: report id 5, threshold 100, centre pa 3 / tpc 2, edge pa 6 / tpc 3,
    // downlink edge groups 2..5, uplink edge blocks 120..126, centre barred from edge
    add_row(KIND_TPC,    16'h0000, 7'd0,   6'd5,  8'd0,   1'b1, outcome(0, 1, 0, 0, 0, 0));
    add_row(KIND_REPORT, 16'h0000, 7'd0,   6'd63, 8'd0,   1'b1, outcome(0, 0, 0, 0, 1, 0));
    add_row(KIND_REPORT, 16'h0000, 7'd0,   6'd5,  8'd0,   1'b1, outcome(0, 0, 1, 6, 0, 0));
    add_row(KIND_TPC,    16'h0000, 7'd0,   6'd5,  8'd0,   1'b1, outcome(0, 3, 0, 0, 0, 0));
    add_row(KIND_DL,     16'h0000, 7'd2,   6'd0,  8'd0,   1'b0, '0);
    add_row(KIND_DL,     16'h0000, 7'd127, 6'd0,  8'd0,   1'b0, '0);
    add_row(KIND_REPORT, 16'hFFFF, 7'd127, 6'd5,  8'd255, 1'b1, outcome(0, 0, 1, 3, 0, 0));
    add_row(KIND_TPC,    16'hFFFF, 7'd0,   6'd0,  8'd0,   1'b1, outcome(0, 2, 0, 0, 0, 0));
    add_row(KIND_DL,     16'hFFFF, 7'd3,   6'd0,  8'd0,   1'b0, '0);
    add_row(KIND_UL,     16'hFFFF, 7'd127, 6'd0,  8'd0,   1'b0, '0);
    add_row(KIND_UL,     16'h1234, 7'd120, 6'd0,  8'd0,   1'b0, '0);
    add_row(KIND_REPORT, 16'h1234, 7'd0,   6'd5,  8'd99,  1'b1, outcome(0, 0, 1, 6, 0, 0));
    add_row(KIND_REPORT, 16'h1234, 7'd0,   6'd5,  8'd99,  1'b1, outcome(0, 0, 0, 0, 0, 0));
    add_row(KIND_REPORT, 16'h1234, 7'd0,   6'd5,  8'd100, 1'b1, outcome(0, 0, 1, 3, 0, 0));
    add_row(KIND_DL,     16'h5555, 7'd0,   6'd0,  8'd0,   1'b0, '0);
    add_row(KIND_TPC,    16'h5555, 7'd0,   6'd0,  8'd0,   1'b1, outcome(0, 1, 0, 0, 0, 0));
    add_row(KIND_UL,     16'hAAAA, 7'd126, 6'd0,  8'd0,   1'b0, '0);
    add_row(KIND_REPORT, 16'hAAAA, 7'd0,   6'd0,  8'd0,   1'b1, outcome(0, 0, 0, 0, 1, 0));
    add_row(KIND_DL,     16'h00FF, 7'd5,   6'd0,  8'd0,   1'b0, '0);
    add_row(KIND_DL,     16'hFF00, 7'd6,   6'd0,  8'd0,   1'b0, '0);
    add_row(KIND_UL,     16'h0000, 7'd0,   6'd0,  8'd0,   1'b0, '0);
    add_row(KIND_TPC,    16'h8001, 7'd0,   6'd0,  8'd0,   1'b1, outcome(0, 1, 0, 0, 0, 0));

    // synchronous reset, released at a falling edge
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int p = 0; p <= 4; p++) begin
      drain_results();
      plan_phase(p);
      program_regs();
      if (p == 0) begin
        foreach (directed_rows[r])
          send_item(directed_rows[r].item, directed_rows[r].typed, directed_rows[r].want);
      end else begin
        for (int n = 0; n < PHASE_ITEMS; n++) begin
          // occasional full hold-off mid phase
          if ($urandom_range(199) == 0) drain_results();
          pick = $urandom_range(9);
          it.kind = (pick < 3) ? KIND_DL : (pick < 5) ? KIND_UL :
                    (pick < 7) ? KIND_TPC : KIND_REPORT;
          // mostly a recurring set of terminals, sometimes a fresh one
          it.rnti = ($urandom_range(6) == 0) ? 16'($urandom)
                                             : rnti_pool[$urandom_range(POOL_SIZE - 1)];
          it.group_index = 7'($urandom_range(127));
          it.report_id = ($urandom_range(6) == 0) ? 6'($urandom_range(63)) : mode_q[7:2];
          it.rsrq = ($urandom_range(3) == 0) ? thr_q - 8'($urandom_range(1))
                                             : 8'($urandom_range(255));
          send_item(it, 1'b0, '0);
        end
      end
    end

    drain_results();
    repeat (100) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[soft_frequency_reuse_rbg_policy] OK");
    end else begin
      $display("[soft_frequency_reuse_rbg_policy] ERROR");
    end
    $finish;
  end

endmodule

/* files.f */
src/sfr_pkg.sv
src/sfr_ctrl.sv
src/sfr_datapath.sv
src/soft_frequency_reuse_rbg_policy.sv
src/sfr_checker.sv
verif/tb_soft_frequency_reuse_rbg_policy.sv
